### design/ppbl_pkg.sv
// Package: types and constants shared by the parallel-port bridge link design.
`timescale 1ns / 1ps
`default_nettype none

package ppbl_pkg;

    localparam logic [2:0] CMD_DATA_WR = 3'd0;
    localparam logic [2:0] CMD_CTRL_WR = 3'd1;
    localparam logic [2:0] CMD_STAT_RD = 3'd2;
    localparam logic [2:0] CMD_EPP_AW  = 3'd3;
    localparam logic [2:0] CMD_EPP_DW  = 3'd4;
    localparam logic [2:0] CMD_EPP_AR  = 3'd5;
    localparam logic [2:0] CMD_EPP_DR  = 3'd6;

    localparam int CT_STROBE_BIT = 0;
    localparam int CT_AUTOFD_BIT = 1;
    localparam int CT_INIT_BIT   = 2;
    localparam int CT_SELECT_BIT = 3;

    localparam logic [3:0] CT_STROBE = 4'h1;
    localparam logic [3:0] CT_AUTOFD = 4'h2;
    localparam logic [3:0] CT_INIT   = 4'h4;
    localparam logic [3:0] CT_SELECT = 4'h8;

    localparam logic [7:0] ST_ACK  = 8'h40;
    localparam logic [7:0] ST_BUSY = 8'h80;
    localparam logic [7:0] ST_MASK = 8'hf8;
    localparam logic [7:0] ST_IDLE = 8'hd8;

    localparam logic [7:0] MODE_REG     = 8'h04;
    localparam logic [7:0] MODE_FIELD   = 8'h18;
    localparam logic [7:0] MODE_SEL_EPP = 8'h18;
    localparam logic [7:0] MODE_SEL_BYTE = 8'h10;
    localparam logic [7:0] EPP_ADDR_RD_VAL = 8'hff;

    localparam logic [1:0] MODE_NIBBLE = 2'd0;
    localparam logic [1:0] MODE_BYTE   = 2'd1;
    localparam logic [1:0] MODE_EPP    = 2'd2;

    typedef struct packed {
        logic [7:0] data_latch;
        logic [7:0] control_latch;
        logic       connected;
        logic [1:0] knock_count;
        logic       ident_phase;
        logic       latching;
        logic       committed;
        logic [7:0] reg_ptr;
        logic [7:0] read_hold;
        logic       high_next;
        logic [1:0] mode;
        logic [7:0] status_out;
    } link_state_t;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } store_wr_t;

    typedef struct packed {
        logic [7:0] status_lines;
        logic [7:0] data_lines;
        logic       data_driven;
        logic       link_up;
    } result_t;

endpackage

`default_nettype wire

### design/ppbl_req_if.sv
// Interface: host access request channel.
`timescale 1ns / 1ps
`default_nettype none

interface ppbl_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

### design/ppbl_rsp_if.sv
// Interface: access result channel.
`timescale 1ns / 1ps
`default_nettype none

interface ppbl_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_lines;
    logic [7:0] data_lines;
    logic       data_driven;
    logic       link_up;

    modport source (output valid, output status_lines, output data_lines,
                    output data_driven, output link_up, input ready);
    modport sink   (input valid, input status_lines, input data_lines,
                    input data_driven, input link_up, output ready);
endinterface

`default_nettype wire

### design/ppbl_ctrl.sv
// Link control: next-state, store write and result for one host access.
`timescale 1ns / 1ps
`default_nettype none

module ppbl_ctrl
    import ppbl_pkg::*;
(
    input  link_state_t cur,
    input  logic [2:0]  cmd,
    input  logic [7:0]  value,
    input  logic [1:0]  unit_address,
    input  logic [7:0]  store_rd,
    output link_state_t nxt,
    output store_wr_t   wr,
    output result_t     res
);

    function automatic logic [7:0] nibble_code(input logic [3:0] v);
        return {v[3], 1'b0, v[2:0], 3'b000};
    endfunction

    function automatic logic [7:0] link_answer(input logic [1:0] m);
        return (m == MODE_EPP) ? (ST_ACK | ST_BUSY) : ST_ACK;
    endfunction

    logic [3:0] chg;
    logic [3:0] lines;
    logic [3:0] prev_lines;
    logic       do_close;
    logic       go_on;
    logic       drove;
    logic [7:0] drove_val;
    logic [1:0] knock_inc;
    logic [7:0] id_val;
    logic [7:0] stat;

    assign chg        = cur.control_latch[3:0] ^ value[3:0];
    assign lines      = value[3:0];
    assign prev_lines = cur.control_latch[3:0];
    assign knock_inc  = cur.knock_count + 2'd1;

    always_comb
    begin
        nxt       = cur;
        wr        = '0;
        wr.addr   = cur.reg_ptr;
        drove     = 1'b0;
        drove_val = 8'h00;
        do_close  = 1'b0;
        go_on     = 1'b0;

        unique case (cmd)
            CMD_DATA_WR:
            begin
                nxt.data_latch  = value;
                nxt.knock_count = 2'd0;
                drove           = 1'b1;
                drove_val       = value;
            end
            CMD_CTRL_WR:
            begin
                nxt.control_latch = value;
                if (chg != 4'h0)
                begin
                    if (cur.latching)
                    begin
                        if (chg[CT_AUTOFD_BIT])
                        begin
                            wr.we         = 1'b1;
                            wr.data       = cur.data_latch;
                            nxt.committed = 1'b1;
                        end
                        if (!lines[CT_STROBE_BIT])
                        begin
                            nxt.latching = 1'b0;
                            if (!(cur.committed || chg[CT_AUTOFD_BIT]))
                                do_close = 1'b1;
                        end
                    end
                    else if (cur.connected && lines == (CT_STROBE | CT_SELECT))
                    begin
                        nxt.latching  = 1'b1;
                        nxt.committed = 1'b0;
                        nxt.reg_ptr   = cur.data_latch;
                        nxt.high_next = 1'b0;
                    end
                    else if (cur.connected && prev_lines == CT_AUTOFD
                             && lines[CT_SELECT_BIT])
                    begin
                        do_close = 1'b1;
                    end
                    else if (cur.ident_phase)
                    begin
                        if (chg[CT_SELECT_BIT])
                            nxt.ident_phase = 1'b0;
                    end
                    else if ((lines & ~CT_SELECT) != CT_INIT)
                    begin
                        nxt.knock_count = 2'd0;
                        go_on           = 1'b1;
                    end
                    else if (chg[CT_SELECT_BIT])
                    begin
                        nxt.knock_count = knock_inc;
                        if (knock_inc == 2'd3)
                        begin
                            nxt.knock_count = 2'd0;
                            if (cur.data_latch == {6'd0, unit_address})
                            begin
                                nxt.connected   = 1'b1;
                                nxt.ident_phase = 1'b1;
                                nxt.high_next   = 1'b0;
                                nxt.status_out  = link_answer(cur.mode);
                            end
                        end
                    end
                    else
                    begin
                        go_on = 1'b1;
                    end

                    if (go_on && cur.connected)
                    begin
                        if (chg[CT_AUTOFD_BIT])
                        begin
                            nxt.reg_ptr    = cur.data_latch;
                            nxt.high_next  = 1'b0;
                            nxt.status_out = link_answer(cur.mode);
                        end
                        else if (chg[CT_INIT_BIT])
                        begin
                            if (lines[CT_STROBE_BIT])
                            begin
                                wr.we   = 1'b1;
                                wr.data = cur.data_latch;
                            end
                            else if (cur.mode == MODE_BYTE)
                            begin
                                nxt.status_out = 8'h00;
                                drove          = 1'b1;
                                drove_val      = store_rd;
                            end
                            else if (cur.high_next)
                            begin
                                nxt.status_out = nibble_code(cur.read_hold[7:4]);
                                nxt.high_next  = 1'b0;
                            end
                            else
                            begin
                                nxt.read_hold  = store_rd;
                                nxt.status_out = nibble_code(store_rd[3:0]);
                                nxt.high_next  = 1'b1;
                            end
                        end
                    end

                    if (do_close && cur.connected)
                    begin
                        nxt.connected   = 1'b0;
                        nxt.knock_count = 2'd0;
                        nxt.ident_phase = 1'b0;
                        nxt.latching    = 1'b0;
                        nxt.status_out  = 8'h00;
                    end
                end
            end
            CMD_EPP_AW:
            begin
                nxt.reg_ptr   = value;
                nxt.high_next = 1'b0;
            end
            CMD_EPP_DW:
            begin
                wr.we   = 1'b1;
                wr.data = value;
            end
            CMD_EPP_AR:
            begin
                drove     = 1'b1;
                drove_val = EPP_ADDR_RD_VAL;
            end
            CMD_EPP_DR:
            begin
                drove     = 1'b1;
                drove_val = store_rd;
            end
            default:
            begin
            end
        endcase

        if (wr.we && wr.addr == MODE_REG)
        begin
            if ((wr.data & MODE_FIELD) == MODE_SEL_EPP)
                nxt.mode = MODE_EPP;
            else if ((wr.data & MODE_FIELD) == MODE_SEL_BYTE)
                nxt.mode = MODE_BYTE;
            else
                nxt.mode = MODE_NIBBLE;
        end
    end

    always_comb
    begin
        id_val = nxt.control_latch[CT_AUTOFD_BIT] ? {6'd0, unit_address}
                                                  : ~{6'd0, unit_address};
        if (nxt.connected && nxt.ident_phase)
            stat = link_answer(nxt.mode) | {2'b00, id_val[2:0], 3'b000};
        else if (nxt.connected)
            stat = nxt.status_out;
        else
            stat = ST_IDLE;
        res.status_lines = stat & ST_MASK;
        res.data_lines   = drove ? drove_val : 8'h00;
        res.data_driven  = drove;
        res.link_up      = nxt.connected;
    end

endmodule

`default_nettype wire

### design/ppbl_out_buf.sv
// Two-entry result buffer between the link logic and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module ppbl_out_buf
    import ppbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push_data,
    output logic       can_push,
    ppbl_rsp_if.source rsp
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    head_reg;
    result_t    tail_reg;
    logic       pop;

    assign pop      = rsp.valid && rsp.ready;
    assign can_push = (count_reg != 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
                head_reg <= push_data;
            else
                tail_reg <= push_data;
        end
        else if (pop && !push)
        begin
            head_reg <= tail_reg;
        end
        else if (pop && push)
        begin
            if (count_reg == 2'd1)
                head_reg <= push_data;
            else
            begin
                head_reg <= tail_reg;
                tail_reg <= push_data;
            end
        end
    end

    assign rsp.valid        = (count_reg != 2'd0);
    assign rsp.status_lines = head_reg.status_lines;
    assign rsp.data_lines   = head_reg.data_lines;
    assign rsp.data_driven  = head_reg.data_driven;
    assign rsp.link_up      = head_reg.link_up;

endmodule

`default_nettype wire

### design/parallel_port_bridge_link_top.sv
// Top level: parallel-port bridge link, device side, with register store.
//
//  Channel | Dir | Payload                                          | Transfer
//  req     | in  | cmd[2:0], value[7:0]                             | valid && ready
//  rsp     | out | status_lines, data_lines, data_driven, link_up   | valid && ready
//  cfg     | in  | cfg_wdata[1:0] (unit address)                    | cfg_we
//
//  One access per cycle while req is ready; its result is registered into the result
//  buffer and reaches rsp behind any results still held. Store reads use the pointer
//  prefetched into a synchronous RAM read, with write-to-read forwarding; per-entry
//  valid bits make the store read as zero from reset, so no clearing pass is needed.
//  A two-entry result buffer keeps req ready while one result waits; req stalls
//  only when both entries are held.
`timescale 1ns / 1ps
`default_nettype none

module parallel_port_bridge_link_top
    import ppbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ppbl_req_if.sink   req,
    ppbl_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    link_state_t state_reg;
    link_state_t state_next;
    store_wr_t   wr;
    result_t     res;
    logic [1:0]  unit_address_reg;
    logic        accept;
    logic        can_push;
    logic        mem_we;
    logic [7:0]  rd_addr;

    logic [7:0]  store_mem [256];
    logic [255:0] entry_valid_reg;
    logic [7:0]  rd_data_reg;
    logic        rd_valid_reg;
    logic        fwd_hit_reg;
    logic [7:0]  fwd_data_reg;
    logic        fwd_hit;
    logic [7:0]  store_rd;

    assign req.ready = can_push;
    assign accept    = req.valid && can_push;
    assign mem_we    = accept && wr.we;
    assign rd_addr   = accept ? state_next.reg_ptr : state_reg.reg_ptr;
    assign fwd_hit   = mem_we && (wr.addr == rd_addr);
    assign store_rd  = !rd_valid_reg ? 8'h00 : (fwd_hit_reg ? fwd_data_reg : rd_data_reg);

    ppbl_ctrl u_ctrl (
        .cur          (state_reg),
        .cmd          (req.cmd),
        .value        (req.value),
        .unit_address (unit_address_reg),
        .store_rd     (store_rd),
        .nxt          (state_next),
        .wr           (wr),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '0;
            unit_address_reg <= 2'd0;
            entry_valid_reg  <= '0;
            rd_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                unit_address_reg <= cfg_wdata;
            if (accept)
                state_reg <= state_next;
            if (mem_we)
                entry_valid_reg[wr.addr] <= 1'b1;
            rd_valid_reg <= entry_valid_reg[rd_addr] | fwd_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[wr.addr] <= wr.data;
        rd_data_reg  <= store_mem[rd_addr];
        fwd_hit_reg  <= fwd_hit;
        fwd_data_reg <= wr.data;
    end

    ppbl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .can_push  (can_push),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

### design/ppbl_checker.sv
// Checker: port-level assertions for the bridge link top, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ppbl_checker
    import ppbl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [7:0] status_lines,
    input wire logic [7:0] data_lines,
    input wire logic       data_driven,
    input wire logic       link_up
);

    logic xfer;
    assign xfer = rsp_valid && rsp_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status_lines)
            && $stable(data_lines) && $stable(data_driven) && $stable(link_up))
        else $error("rsp payload changed while stalled");

    a_idle_status: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !link_up |-> status_lines == ST_IDLE)
        else $error("link down but status not idle");

    a_undriven_zero: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !data_driven |-> data_lines == 8'h00)
        else $error("data lines nonzero without drive");

    a_status_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> status_lines[2:0] == 3'b000)
        else $error("status low bits set");

endmodule

bind parallel_port_bridge_link_top ppbl_checker u_ppbl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status_lines (rsp.status_lines),
    .data_lines   (rsp.data_lines),
    .data_driven  (rsp.data_driven),
    .link_up      (rsp.link_up)
);

`default_nettype wire
